// ===== design/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermometer scratchpad decode package
// Shared types, constants and the bytewise CRC-8 function for the decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // Number of scratchpad bytes in one frame; the last one carries the CRC.
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned CNT_W       = 4;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

  // Reflected form of x^8 + x^5 + x^4 + 1.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  // Count-per-degree value that enables the count-remain refinement.
  localparam logic [7:0]  COUNT_PER_C   = 8'h10;
  localparam logic [15:0] SHORT_MASK    = 16'hFFF0;
  localparam logic [15:0] SHORT_OFFSET  = 16'd12;

  // Resolution field of the config byte (bits 6:5).
  typedef enum logic [1:0] {
    RES_9BIT  = 2'b00,
    RES_10BIT = 2'b01,
    RES_11BIT = 2'b10,
    RES_12BIT = 2'b11
  } res_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  // One byte of the reflected CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFL;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== design/tsd_if.sv =====
// ----------------------------------------------------------------------------
// Thermometer scratchpad decode channels
// Valid/ready channels for scratchpad bytes and for decoded results.
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       short_family;

  modport source (output valid, output data_byte, output frame_start,
                  output short_family, input ready);
  modport sink   (input valid, input data_byte, input frame_start,
                  input short_family, output ready);
endinterface

interface tsd_out_if;
  logic               valid;
  logic               ready;
  tsd_pkg::status_t   status;
  logic signed [15:0] temperature_centi;

  modport source (output valid, output status, output temperature_centi,
                  input ready);
  modport sink   (input valid, input status, input temperature_centi,
                  output ready);
endinterface

// ===== design/thermometer_scratchpad_decode_core.sv =====
// ----------------------------------------------------------------------------
// Thermometer scratchpad decode core
// Path: the ninth byte waits in the input register until its result is loaded into the output register.
// Throughput: one byte per cycle while the result side keeps up; bytes that
//   give no result pass through even while a result waits to be read.
// Reset: synchronous, active low; clears the byte count and both valid flags.
// ----------------------------------------------------------------------------
// Bytes are captured in an input register. In the next cycle the byte is
// folded into the running CRC, the OR of all bytes and the latched scratchpad
// fields. On the ninth byte the status and the temperature in hundredths of a
// degree are computed and loaded into the output register. A byte that gives
// no result drains from the input register in every cycle, and a ninth byte
// drains whenever the output register is free or is being read, so a new byte
// can be taken in every cycle unless a ninth byte is held up.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decode_core (
  input  logic      clk,
  input  logic      rst_n,
  tsd_in_if.sink    in_ch,
  tsd_out_if.source out_ch
);
  import tsd_pkg::*;

  // Input register.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        s1_short_r;

  // Frame accumulators and latched scratchpad fields.
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]  crc_accum_r, crc_accum_nxt;
  logic [7:0]  or_accum_r, or_accum_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [7:0]  resolution_byte_r, resolution_byte_nxt;
  logic [7:0]  count_remain_r, count_remain_nxt;
  logic [7:0]  count_per_degree_r, count_per_degree_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic signed [15:0] out_temp_r, out_temp_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             s1_go;
  logic             s1_last;
  logic [CNT_W-1:0] pos;
  logic             restart;
  logic [7:0]       crc_base;
  logic [7:0]       or_base;
  logic [7:0]       or_all;
  logic [15:0]      raw;
  logic [15:0]      raw_short;
  res_t             res_sel;
  logic signed [22:0] centi_prod;

  // A byte that gives no result always moves on; the ninth byte moves on
  // only when the output register can take its result.
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_last || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_xfer) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.frame_start;
      s1_short_r <= in_ch.short_family;
    end
  end

  // A frame restarts on an explicit start flag or whenever the count is at
  // zero, which covers the first byte after reset and after a finished frame.
  assign restart  = s1_start_r || (byte_count_r == '0);
  assign pos      = restart ? '0 : byte_count_r;
  assign s1_last  = s1_valid_r && (pos >= LAST_POS);
  assign crc_base = restart ? 8'h00 : crc_accum_r;
  assign or_base  = restart ? 8'h00 : or_accum_r;
  assign or_all   = or_base | s1_byte_r;

  always_comb begin
    byte_count_nxt       = byte_count_r;
    crc_accum_nxt        = crc_accum_r;
    or_accum_nxt         = or_accum_r;
    temp_word_nxt        = temp_word_r;
    resolution_byte_nxt  = resolution_byte_r;
    count_remain_nxt     = count_remain_r;
    count_per_degree_nxt = count_per_degree_r;
    if (s1_go) begin
      or_accum_nxt = or_all;
      if (pos < LAST_POS) begin
        crc_accum_nxt  = crc8_update(crc_base, s1_byte_r);
        byte_count_nxt = pos + CNT_W'(1);
        case (pos)
          CNT_W'(0): temp_word_nxt[7:0]   = s1_byte_r;
          CNT_W'(1): temp_word_nxt[15:8]  = s1_byte_r;
          CNT_W'(4): resolution_byte_nxt  = s1_byte_r;
          CNT_W'(6): count_remain_nxt     = s1_byte_r;
          CNT_W'(7): count_per_degree_nxt = s1_byte_r;
          default: ;
        endcase
      end else begin
        crc_accum_nxt  = crc_base;
        byte_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
    crc_accum_r        <= crc_accum_nxt;
    or_accum_r         <= or_accum_nxt;
    temp_word_r        <= temp_word_nxt;
    resolution_byte_r  <= resolution_byte_nxt;
    count_remain_r     <= count_remain_nxt;
    count_per_degree_r <= count_per_degree_nxt;
  end

  // Raw temperature. The short family has half-degree steps in bits 8:0, so
  // it is moved up to sixteenths and optionally refined with count-remain.
  // The long family drops the low bits that its resolution leaves undefined.
  assign res_sel = res_t'(resolution_byte_r[6:5]);

  always_comb begin
    raw_short = {temp_word_r[12:0], 3'b000};
    if (count_per_degree_r == COUNT_PER_C) begin
      raw_short = (raw_short & SHORT_MASK) + SHORT_OFFSET - {8'h00, count_remain_r};
    end
    if (s1_short_r) begin
      raw = raw_short;
    end else begin
      unique case (res_sel)
        RES_9BIT:  raw = {temp_word_r[15:3], 3'b000};
        RES_10BIT: raw = {temp_word_r[15:2], 2'b00};
        RES_11BIT: raw = {temp_word_r[15:1], 1'b0};
        RES_12BIT: raw = temp_word_r;
        default:   raw = temp_word_r;
      endcase
    end
  end

  // Hundredths of a degree: signed raw times 100, floor divided by 16.
  assign centi_prod = $signed({{7{raw[15]}}, raw}) * 23'sd100;

  always_comb begin
    out_status_nxt = out_status_r;
    out_temp_nxt   = out_temp_r;
    if (s1_go && s1_last) begin
      // The all-zero check comes first, since all zeros has a matching CRC.
      if (or_all == 8'h00) begin
        out_status_nxt = ST_ZERO;
        out_temp_nxt   = '0;
      end else if (crc_base != s1_byte_r) begin
        out_status_nxt = ST_CRC_ERR;
        out_temp_nxt   = '0;
      end else begin
        out_status_nxt = ST_OK;
        out_temp_nxt   = centi_prod[19:4];
      end
    end
  end

  always_comb begin
    if (s1_go && s1_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_temp_r   <= out_temp_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.temperature_centi = out_temp_r;

  // Error results never carry a temperature.
  a_err_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_temp_r == '0))
    else $error("error result with nonzero temperature");

  // The byte count never runs past the CRC byte position.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= LAST_POS)
    else $error("byte count out of range");

  // An empty output register only fills through the last byte of a frame.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(s1_go && s1_last)) |=> !out_valid_r)
    else $error("result produced by a non-final byte");

  // An empty input register always takes a new byte.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty input register");

endmodule

// ===== sim/thermometer_scratchpad_decode_core_test.sv =====
// ----------------------------------------------------------------------------
// Thermometer scratchpad decode core testbench
// Streams scratchpad frames into the decoder and checks every decoded reading
// (status and temperature in hundredths of a degree) against a cycle-free
// software decode of the same bytes, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decode_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsd_pkg::*;

  // Run limits. The cycle limit leaves a wide margin over the slowest legal
  // run.
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned HOLD_LEN      = 400;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MAX_PRINTS    = 50;

  // One byte on the input channel, as the generator queues it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       short_family;
  } scratch_byte_t;

  // One decoded reading, as the result channel carries it.
  typedef struct packed {
    status_t            status;
    logic signed [15:0] centi;
  } reading_t;

  logic clk;
  logic rst_n;

  tsd_in_if  in_ch ();
  tsd_out_if out_ch ();

  thermometer_scratchpad_decode_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be offered, and readings that the decoder still owes us.
  scratch_byte_t scratchpad_bytes[$];
  reading_t      pending_readings[$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned items_pushed = 0;

  // Idling knobs, changed by the sequencer between phases only.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Long receiver hold-off: requested by the sequencer, timed by the ready
  // process itself, which raises hold_done when the stretch is over.
  bit          long_hold   = 1'b0;
  bit          hold_done   = 1'b0;
  int unsigned hold_cycles = 0;

  // Byte position the generator believes the decoder is at. It follows the
  // same framing rules as the decoder so that well-formed frames can be built
  // with or without an explicit frame start.
  logic [3:0] gen_pos = '0;

  // Shadow copy of the decoder state, advanced once per accepted transfer.
  logic [3:0]  frame_pos        = '0;
  logic [7:0]  crc_run          = '0;
  logic [7:0]  or_run           = '0;
  logic [15:0] temp_latch       = '0;
  logic [7:0]  config_latch     = '0;
  logic [7:0]  remain_latch     = '0;
  logic [7:0]  per_degree_latch = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Reflected CRC-8, one byte at a time. The polynomial is shifted in from
  // the low end, so the low bit decides whether it is folded in.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] acc;
    acc = crc_in ^ data;
    repeat (8) begin
      acc = {1'b0, acc[7:1]} ^ (acc[0] ? CRC_POLY_REFL : 8'h00);
    end
    return acc;
  endfunction

  // --------------------------------------------------------------------------
  // Software decode of one accepted byte. Returns 1 when the byte closes a
  // frame, with the reading that the decoder must produce for it.
  // --------------------------------------------------------------------------
  function automatic bit decode_scratchpad_byte(input scratch_byte_t sb,
                                                output reading_t rd);
    logic [3:0]         pos;
    logic [15:0]        raw;
    logic signed [31:0] scaled;

    rd = '{status: ST_OK, centi: '0};

    // A frame start, or any byte that arrives between frames, opens a new
    // frame; a partial frame in flight is dropped without a result.
    if (sb.frame_start || frame_pos == '0) begin
      crc_run = '0;
      or_run  = '0;
      pos     = '0;
    end else begin
      pos = frame_pos;
    end

    or_run = or_run | sb.data_byte;

    if (pos != LAST_POS) begin
      crc_run = crc8_fold(crc_run, sb.data_byte);
      case (pos)
        4'd0: temp_latch[7:0]  = sb.data_byte;
        4'd1: temp_latch[15:8] = sb.data_byte;
        4'd4: config_latch     = sb.data_byte;
        4'd6: remain_latch     = sb.data_byte;
        4'd7: per_degree_latch = sb.data_byte;
        default: ;
      endcase
      frame_pos = pos + 4'd1;
      return 1'b0;
    end

    // Ninth byte: the frame is closed whatever its outcome.
    frame_pos = '0;

    // The all-zero check wins over the CRC check, since a frame of zeros has
    // a matching CRC of zero.
    if (or_run == '0) begin
      rd.status = ST_ZERO;
      return 1'b1;
    end
    if (crc_run != sb.data_byte) begin
      rd.status = ST_CRC_ERR;
      return 1'b1;
    end

    raw = temp_latch;
    if (sb.short_family) begin
      // The short family reports half degrees; scale to sixteenths and, when
      // the count-per-degree is the expected one, refine with count-remain.
      raw = raw << 3;
      if (per_degree_latch == COUNT_PER_C) begin
        raw = (raw & SHORT_MASK) + SHORT_OFFSET - {8'h00, remain_latch};
      end
    end else begin
      // Low bits below the configured resolution are undefined on the wire.
      case (res_t'(config_latch[6:5]))
        RES_9BIT:  raw[2:0] = '0;
        RES_10BIT: raw[1:0] = '0;
        RES_11BIT: raw[0]   = 1'b0;
        default: ;
      endcase
    end

    // Sixteenths to hundredths with floor rounding, kept to 16 bits.
    scaled   = $signed({{16{raw[15]}}, raw}) * 32'sd100;
    rd.centi = scaled[19:4];
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Generator side: queue bytes and whole frames, tracking the frame position
  // the decoder will be at when each byte is taken.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data, input bit start, input bit shortf);
    scratchpad_bytes.push_back('{data_byte: data, frame_start: start, short_family: shortf});
    if (start || gen_pos == '0) begin
      gen_pos = 4'd1;
    end else if (gen_pos == LAST_POS) begin
      gen_pos = '0;
    end else begin
      gen_pos = gen_pos + 4'd1;
    end
    items_pushed++;
  endtask

  // Eight data bytes followed by their CRC. A corrupted frame carries a CRC
  // with some bits flipped. Only the ninth byte's family flag matters, so the
  // others are random.
  task automatic push_frame(input logic [7:0][7:0] body, input bit use_start,
                            input bit shortf, input logic [7:0] crc_flip);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      crc = crc8_fold(crc, body[i]);
      push_byte(body[i], (i == 0) && use_start, 1'($urandom_range(1)));
    end
    push_byte(crc ^ crc_flip, 1'b0, shortf);
  endtask

  // Random frame content, biased toward the interesting corners: extreme
  // temperature bytes, the refinement count-per-degree and all resolutions.
  task automatic push_random_frame(input logic [7:0] crc_flip, input bit zero_body);
    logic [7:0][7:0] body;
    bit              use_start;
    for (int i = 0; i < 8; i++) begin
      body[i] = 8'($urandom_range(255));
    end
    case ($urandom_range(5))
      0: body[1] = 8'h00;
      1: body[1] = 8'hFF;
      2: body[1] = 8'h7F;
      3: body[1] = 8'h80;
      default: ;
    endcase
    if ($urandom_range(1)) begin
      body[7] = COUNT_PER_C;
    end
    if (zero_body) begin
      body = '0;
    end
    // Between frames the start flag may be left out, as the decoder then
    // opens a frame on its own.
    use_start = (gen_pos == '0) ? bit'($urandom_range(1)) : 1'b1;
    push_frame(body, use_start, 1'($urandom_range(1)), crc_flip);
  endtask

  // Random bytes with sparse frame starts: truncated frames, restarts and
  // frames that close on arbitrary data.
  task automatic push_noise();
    int unsigned n;
    n = $urandom_range(12, 1);
    repeat (n) begin
      push_byte(8'($urandom_range(255)), $urandom_range(99) < 20, 1'($urandom_range(1)));
    end
  endtask

  task automatic push_random_mix();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      push_random_frame(8'h00, 1'b0);
    end else if (pick < 80) begin
      push_random_frame(8'($urandom_range(255, 1)), 1'b0);
    end else if (pick < 85) begin
      push_random_frame(8'h00, 1'b1);
    end else begin
      push_noise();
    end
  endtask

  // Sender pause: nothing more is offered until every queued byte has been
  // taken and every owed reading has come out, plus a slack of DRAIN_CYCLES.
  task automatic wait_quiet();
    while (scratchpad_bytes.size() != 0 || in_ch.valid || pending_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver. At each edge it first records a transfer that completed on
  // this edge, then decides what to offer next. valid is assigned at most
  // once per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    scratch_byte_t sent;
    scratch_byte_t nxt;
    reading_t      rd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        sent.data_byte    = in_ch.data_byte;
        sent.frame_start  = in_ch.frame_start;
        sent.short_family = in_ch.short_family;
        if (decode_scratchpad_byte(sent, rd)) begin
          pending_readings.push_back(rd);
        end
      end
      // The slot is free unless a byte is on offer and was not taken.
      if (!in_ch.valid || in_ch.ready === 1'b1) begin
        if (scratchpad_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = scratchpad_bytes.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.data_byte    <= nxt.data_byte;
          in_ch.frame_start  <= nxt.frame_start;
          in_ch.short_family <= nxt.short_family;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready. During the long hold-off it counts its own cycles and
  // keeps ready low, so the decoder fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Reading checker: each transfer on the result channel is matched against
  // the oldest owed reading, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        log_mismatch($sformatf("reading with none owed: status %0d centi %0d",
                               out_ch.status, out_ch.temperature_centi));
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.status !== want.status) begin
          log_mismatch($sformatf("status %0d, wanted %0d", out_ch.status, want.status));
        end
        if (out_ch.temperature_centi !== want.centi) begin
          log_mismatch($sformatf("temperature %0d, wanted %0d",
                                 out_ch.temperature_centi, want.centi));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. All queue and knob updates happen on the falling edge, away
  // from the edge at which the driver and checker sample.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [7:0][7:0] body;

    rst_n = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames. First an all-zero frame sent without a frame start:
    // the decoder must open it on its own and flag the zero data, although
    // the CRC of zeros matches.
    push_frame('0, 1'b0, 1'b0, 8'h00);

    // A frame that is cut after one byte and restarted. The restarted frame
    // is short family, with count-remain at its extreme and the refinement on.
    push_byte(8'hFF, 1'b1, 1'b1);
    body[0] = 8'hFF; body[1] = 8'hFF; body[2] = 8'h00; body[3] = 8'h00;
    body[4] = 8'h7F; body[5] = 8'hFF; body[6] = 8'hFF; body[7] = COUNT_PER_C;
    push_frame(body, 1'b1, 1'b1, 8'h00);

    // Most negative temperature word with a broken CRC: the reading must
    // report the error with a zero temperature.
    body[0] = 8'h00; body[1] = 8'h80; body[2] = 8'h55; body[3] = 8'hAA;
    body[4] = 8'h1F; body[5] = 8'h00; body[6] = 8'h0C; body[7] = 8'h10;
    push_frame(body, 1'b1, 1'b0, 8'h80);
    wait_quiet();

    // Random phases: free running, slow sender, slow receiver, light idling
    // on both sides. Each ends with the sender pausing until all is read.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      begin : fill_phase
        int unsigned target;
        target = items_pushed + PHASE_ITEMS;
        while (items_pushed < target) begin
          push_random_mix();
        end
      end
      wait_quiet();

      // After the free-running phase, hold the receiver off for a long
      // stretch while the sender keeps offering whole frames.
      if (ph == 0) begin
        long_hold = 1'b1;
        repeat (6) push_random_frame(8'h00, 1'b0);
        while (!hold_done) @(negedge clk);
        long_hold = 1'b0;
        wait_quiet();
      end
    end

    if (pending_readings.size() != 0) begin
      log_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
